// File: hdl/scp_pkg.sv
// ---------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the shape pair collision pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int NUM_STAGES     = 5;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_CIRCLE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PAIR_NONE       = 2'd0,
        PAIR_BOX_BOX    = 2'd1,
        PAIR_BOX_CIRCLE = 2'd2,
        PAIR_UNSUP      = 2'd3
    } pair_t;

endpackage

`default_nettype wire

// File: hdl/scp_datapath.sv
// ---------------------------------------------------------------------------
// scp_datapath
// Five register stages of box/box and box/circle collision arithmetic.
// Each stage loads when its enable bit is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scp_datapath
    import scp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic [NUM_STAGES-1:0]         en,
    input  wire logic [1:0]                    kind,
    input  wire logic signed [COORD_BITS-1:0]  first_x0,
    input  wire logic signed [COORD_BITS-1:0]  first_y0,
    input  wire logic signed [COORD_BITS-1:0]  first_x1,
    input  wire logic signed [COORD_BITS-1:0]  first_y1,
    input  wire logic [1:0]                    other_kind,
    input  wire logic signed [COORD_BITS-1:0]  second_x0,
    input  wire logic signed [COORD_BITS-1:0]  second_y0,
    input  wire logic signed [COORD_BITS-1:0]  second_x1,
    input  wire logic signed [COORD_BITS-1:0]  second_y1,
    output logic                               hit,
    output logic                               unsupported,
    output logic signed [COORD_BITS+1:0]       depth_x,
    output logic signed [COORD_BITS+1:0]       depth_y
);

    localparam int W   = COORD_BITS;
    localparam int SW  = W + 1;
    localparam int DW  = W + 2;
    localparam int OW  = W + 3;
    localparam int MW  = W - 1;
    localparam int QW  = 2 * MW;
    localparam int SQW = QW + 1;

    // stage 1
    pair_t                pair1_reg, pair1_next;
    logic signed [SW-1:0] sax_reg, sbx_reg, eax_reg, ebx_reg;
    logic signed [SW-1:0] say_reg, sby_reg, eay_reg, eby_reg;
    logic signed [SW-1:0] sax_next, sbx_next, eax_next, ebx_next;
    logic signed [SW-1:0] say_next, sby_next, eay_next, eby_next;
    logic signed [W-1:0]  bx0_reg, by0_reg, cx_reg, cy_reg, r1_reg, tx_reg, ty_reg;
    logic signed [W-1:0]  bx0_next, by0_next, bx1_sel, by1_sel;
    logic signed [W-1:0]  cx_next, cy_next, r1_next, tx_next, ty_next;
    logic                 box_first;

    // stage 2
    pair_t                pair2_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, extx_reg, exty_reg;
    logic signed [DW-1:0] dx_next, dy_next, extx_next, exty_next;
    logic signed [SW-1:0] ddx_reg, ddy_reg, ddx_next, ddy_next;
    logic signed [W-1:0]  clx, cly, r2_reg;

    // stage 3
    pair_t                pair3_reg;
    logic signed [OW-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic signed [OW-1:0] dxw, dyw, absx, absy;
    logic                 dxpos_reg, dypos_reg, dxpos_next, dypos_next;
    logic [SW-1:0]        axu, ayu, rz;
    logic [MW-1:0]        ax_reg, ay_reg, r3_reg;
    logic                 far3_reg, far3_next;

    // stage 4
    pair_t                pair4_reg;
    logic [QW-1:0]        sqx_reg, sqy_reg, rr_reg, sqx_next, sqy_next, rr_next;
    logic                 far4_reg;
    logic                 bbhit_reg, bbhit_next, xsel;
    logic signed [DW-1:0] oxt, oyt;
    logic signed [DW-1:0] bbdx_reg, bbdy_reg, bbdx_next, bbdy_next;

    // output stage
    logic [SQW-1:0]       sqsum;
    logic                 bchit;
    logic                 hit_reg, hit_next, unsup_reg, unsup_next;
    logic signed [DW-1:0] depth_x_reg, depth_y_reg, depth_x_next, depth_y_next;

    // ---- stage 1: classify, corner sums and differences, first clamp bound
    always_comb
    begin
        if (kind == KIND_NONE || other_kind == KIND_NONE)
            pair1_next = PAIR_NONE;
        else if (kind == KIND_BOX && other_kind == KIND_BOX)
            pair1_next = PAIR_BOX_BOX;
        else if ((kind == KIND_BOX && other_kind == KIND_CIRCLE) ||
                 (kind == KIND_CIRCLE && other_kind == KIND_BOX))
            pair1_next = PAIR_BOX_CIRCLE;
        else
            pair1_next = PAIR_UNSUP;

        sax_next = SW'(first_x1) + SW'(first_x0);
        sbx_next = SW'(second_x1) + SW'(second_x0);
        eax_next = SW'(first_x1) - SW'(first_x0);
        ebx_next = SW'(second_x1) - SW'(second_x0);
        say_next = SW'(first_y1) + SW'(first_y0);
        sby_next = SW'(second_y1) + SW'(second_y0);
        eay_next = SW'(first_y1) - SW'(first_y0);
        eby_next = SW'(second_y1) - SW'(second_y0);

        box_first = (kind == KIND_BOX);
        bx0_next  = box_first ? first_x0 : second_x0;
        by0_next  = box_first ? first_y0 : second_y0;
        bx1_sel   = box_first ? first_x1 : second_x1;
        by1_sel   = box_first ? first_y1 : second_y1;
        cx_next   = box_first ? second_x0 : first_x0;
        cy_next   = box_first ? second_y0 : first_y0;
        r1_next   = box_first ? second_x1 : first_x1;
        tx_next   = (cx_next < bx1_sel) ? cx_next : bx1_sel;
        ty_next   = (cy_next < by1_sel) ? cy_next : by1_sel;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pair1_reg <= pair1_next;
            sax_reg   <= sax_next;
            sbx_reg   <= sbx_next;
            eax_reg   <= eax_next;
            ebx_reg   <= ebx_next;
            say_reg   <= say_next;
            sby_reg   <= sby_next;
            eay_reg   <= eay_next;
            eby_reg   <= eby_next;
            bx0_reg   <= bx0_next;
            by0_reg   <= by0_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            r1_reg    <= r1_next;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
        end
    end

    // ---- stage 2: center offsets, summed extents, clamp distance
    always_comb
    begin
        dx_next   = DW'(sax_reg) - DW'(sbx_reg);
        dy_next   = DW'(say_reg) - DW'(sby_reg);
        extx_next = DW'(eax_reg) + DW'(ebx_reg);
        exty_next = DW'(eay_reg) + DW'(eby_reg);
        clx       = (bx0_reg > tx_reg) ? bx0_reg : tx_reg;
        cly       = (by0_reg > ty_reg) ? by0_reg : ty_reg;
        ddx_next  = SW'(clx) - SW'(cx_reg);
        ddy_next  = SW'(cly) - SW'(cy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pair2_reg <= pair1_reg;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            extx_reg  <= extx_next;
            exty_reg  <= exty_next;
            ddx_reg   <= ddx_next;
            ddy_reg   <= ddy_next;
            r2_reg    <= r1_reg;
        end
    end

    // ---- stage 3: overlaps, distance magnitudes, early reject
    always_comb
    begin
        dxw        = OW'(dx_reg);
        dyw        = OW'(dy_reg);
        absx       = dxw[OW-1] ? -dxw : dxw;
        absy       = dyw[OW-1] ? -dyw : dyw;
        ox_next    = OW'(extx_reg) - absx;
        oy_next    = OW'(exty_reg) - absy;
        dxpos_next = !dx_reg[DW-1] && (dx_reg != '0);
        dypos_next = !dy_reg[DW-1] && (dy_reg != '0);

        axu        = ddx_reg[SW-1] ? SW'(-ddx_reg) : SW'(ddx_reg);
        ayu        = ddy_reg[SW-1] ? SW'(-ddy_reg) : SW'(ddy_reg);
        rz         = {1'b0, r2_reg};
        far3_next  = r2_reg[W-1] || (axu > rz) || (ayu > rz);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pair3_reg <= pair2_reg;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            dxpos_reg <= dxpos_next;
            dypos_reg <= dypos_next;
            ax_reg    <= axu[MW-1:0];
            ay_reg    <= ayu[MW-1:0];
            r3_reg    <= r2_reg[MW-1:0];
            far3_reg  <= far3_next;
        end
    end

    // ---- stage 4: squares, box/box decision
    always_comb
    begin
        sqx_next   = QW'(ax_reg) * QW'(ax_reg);
        sqy_next   = QW'(ay_reg) * QW'(ay_reg);
        rr_next    = QW'(r3_reg) * QW'(r3_reg);

        oxt        = ox_reg[DW-1:0];
        oyt        = oy_reg[DW-1:0];
        bbhit_next = (ox_reg > 0) && (oy_reg > 0);
        xsel       = (ox_reg < oy_reg);
        bbdx_next  = '0;
        bbdy_next  = '0;
        if (bbhit_next)
        begin
            if (xsel)
                bbdx_next = dxpos_reg ? oxt : -oxt;
            else
                bbdy_next = dypos_reg ? oyt : -oyt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            pair4_reg <= pair3_reg;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            rr_reg    <= rr_next;
            far4_reg  <= far3_reg;
            bbhit_reg <= bbhit_next;
            bbdx_reg  <= bbdx_next;
            bbdy_reg  <= bbdy_next;
        end
    end

    // ---- output stage
    always_comb
    begin
        sqsum        = SQW'(sqx_reg) + SQW'(sqy_reg);
        bchit        = !far4_reg && (sqsum <= SQW'(rr_reg));
        hit_next     = 1'b0;
        unsup_next   = 1'b0;
        depth_x_next = '0;
        depth_y_next = '0;
        unique case (pair4_reg)
            PAIR_NONE:
            begin
                hit_next = 1'b0;
            end
            PAIR_BOX_BOX:
            begin
                hit_next     = bbhit_reg;
                depth_x_next = bbdx_reg;
                depth_y_next = bbdy_reg;
            end
            PAIR_BOX_CIRCLE:
            begin
                hit_next = bchit;
            end
            PAIR_UNSUP:
            begin
                unsup_next = 1'b1;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            hit_reg     <= hit_next;
            unsup_reg   <= unsup_next;
            depth_x_reg <= depth_x_next;
            depth_y_reg <= depth_y_next;
        end
    end

    assign hit         = hit_reg;
    assign unsupported = unsup_reg;
    assign depth_x     = depth_x_reg;
    assign depth_y     = depth_y_reg;

endmodule

`default_nettype wire

// File: hdl/shape_pair_collision_top.sv
// ---------------------------------------------------------------------------
// shape_pair_collision_top
// Collision test for one pair of 2-D shapes (box or circle) per beat.
//
//   channel   handshake                    payload
//   pair      pair_valid / pair_stall      kind, first_*, other_kind, second_*
//   result    result_valid / result_stall  hit, unsupported, depth_x, depth_y
//
// One beat per cycle sustained while no result stall holds the stages; a beat passes through five stages.
// Every stage loads each cycle unless it and the stages ahead are full under a result stall.
// Reset clears only the stage valid bits.
// A stalled result holds; empty stages keep filling, bubbles are squeezed out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shape_pair_collision_top
    import scp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pair_valid,
    output logic                               pair_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic signed [COORD_BITS-1:0]  first_x0,
    input  wire logic signed [COORD_BITS-1:0]  first_y0,
    input  wire logic signed [COORD_BITS-1:0]  first_x1,
    input  wire logic signed [COORD_BITS-1:0]  first_y1,
    input  wire logic [1:0]                    other_kind,
    input  wire logic signed [COORD_BITS-1:0]  second_x0,
    input  wire logic signed [COORD_BITS-1:0]  second_y0,
    input  wire logic signed [COORD_BITS-1:0]  second_x1,
    input  wire logic signed [COORD_BITS-1:0]  second_y1,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic                               hit,
    output logic                               unsupported,
    output logic signed [COORD_BITS+1:0]       depth_x,
    output logic signed [COORD_BITS+1:0]       depth_y
);

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !result_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end

        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = pair_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign pair_stall   = !en[0];
    assign result_valid = valid_reg[NUM_STAGES-1];

    scp_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .en          (en),
        .kind        (kind),
        .first_x0    (first_x0),
        .first_y0    (first_y0),
        .first_x1    (first_x1),
        .first_y1    (first_y1),
        .other_kind  (other_kind),
        .second_x0   (second_x0),
        .second_y0   (second_y0),
        .second_x1   (second_x1),
        .second_y1   (second_y1),
        .hit         (hit),
        .unsupported (unsupported),
        .depth_x     (depth_x),
        .depth_y     (depth_y)
    );

`ifndef ASSERT_OFF
    a_unsup_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && unsupported |-> !hit && depth_x == '0 && depth_y == '0)
        else $error("unsupported result carries hit or depth");

    a_one_axis: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && depth_x != '0 |-> hit && depth_y == '0)
        else $error("depth on both axes or without hit");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_stall |=> valid_reg[0])
        else $error("accepted beat not captured in first stage");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !pair_stall)
        else $error("input stalled while output stage empty");
`endif

endmodule

`default_nettype wire
